FILE: src/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned DATA_W = 32;

    // Controller -> datapath command
    typedef struct packed {
        logic accept;   // input word taken this cycle
    } t_dq_cmd;

endpackage

`default_nettype wire

FILE: src/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  wire            i_stall,
    output deq_pkg::t_dq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    // Free to take a word when idle, or when the held result leaves this cycle
    always_comb begin
        w_take = 1'b0;
        unique case (r_state)
            S_IDLE: w_take = 1'b1;
            S_OUT:  w_take = !i_stall;
            default: w_take = 1'b0;
        endcase
    end

    assign o_stall      = !w_take;
    assign o_valid      = (r_state == S_OUT);
    assign o_cmd.accept = w_take && i_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall && !i_valid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/deq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  deq_pkg::t_dq_cmd                 i_cmd,
    input  wire  [1:0]                       i_mode,
    input  wire  signed [deq_pkg::DATA_W-1:0] i_push_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_popped_value,
    output logic [1:0]                       o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill_count
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   D_EXT  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] D_FULL = CW'(DEPTH);
    localparam logic [IW-1:0] D_LAST = IW'(DEPTH - 1);

    logic [deq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::DATA_W-1:0] r_rd_data;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_status, n_status;
    logic          r_pop_sel, n_pop_sel;

    logic [CW:0]   w_sum, w_sum_m1, w_tail, w_rear;
    logic [IW-1:0] w_front_dec, w_front_inc, w_addr;
    logic          w_we, w_re, w_full, w_empty;

    // Ring positions: tail = front+count, rear = front+count-1, both mod DEPTH
    assign w_sum       = (CW + 1)'(r_front) + (CW + 1)'(r_count);
    assign w_sum_m1    = w_sum - (CW + 1)'(1);
    assign w_tail      = (w_sum >= D_EXT) ? w_sum - D_EXT : w_sum;
    assign w_rear      = (w_sum_m1 >= D_EXT) ? w_sum_m1 - D_EXT : w_sum_m1;
    assign w_front_dec = (r_front == '0) ? D_LAST : r_front - IW'(1);
    assign w_front_inc = (r_front == D_LAST) ? '0 : r_front + IW'(1);
    assign w_full      = (r_count == D_FULL);
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = deq_pkg::ST_DONE;
        n_pop_sel = 1'b0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_addr    = r_front;
        unique case (i_mode)
            deq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_addr  = w_front_dec;
                    w_we    = 1'b1;
                    n_front = w_front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::MODE_PUSH_REAR: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_addr  = w_tail[IW-1:0];
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_addr    = r_front;
                    w_re      = 1'b1;
                    n_pop_sel = 1'b1;
                    n_front   = w_front_inc;
                    n_count   = r_count - CW'(1);
                end
            end
            deq_pkg::MODE_POP_REAR: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_addr    = w_rear[IW-1:0];
                    w_re      = 1'b1;
                    n_pop_sel = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            default: n_status = deq_pkg::ST_DONE;
        endcase
    end

    // Single-port entry store; read data held until the next accepted pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_we) begin
            r_mem[w_addr] <= i_push_value;
        end
        if (i_cmd.accept && w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_pop_sel <= 1'b0;
        end else if (i_cmd.accept) begin
            r_front   <= n_front;
            r_count   <= n_count;
            r_pop_sel <= n_pop_sel;
        end
    end

    assign o_popped_value = r_pop_sel ? r_rd_data : '0;
    assign o_status       = r_status;
    assign o_fill_count   = r_count;

endmodule

`default_nettype wire

FILE: src/double_ended_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Word
// input    in   i_valid / o_stall    i_mode, i_push_value
// result   out  o_valid / i_stall    o_popped_value, o_status, o_fill_count
//
// One result word per input word, registered, in the cycle after acceptance.
// A new word is taken every cycle while the result side keeps taking results;
// throughput is set by the single read/write port of the entry store.
// Synchronous active-low reset empties the queue (front and count to zero).
// A stalled result holds; input is stalled until the held result is taken.

module double_ended_queue_unit #(
    parameter int unsigned DEPTH = 16   // entries, 2..4096
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input words
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [1:0]                        i_mode,
    input  wire  signed [deq_pkg::DATA_W-1:0] i_push_value,
    // result words
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic signed [deq_pkg::DATA_W-1:0] o_popped_value,
    output logic [1:0]                        o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_fill_count
);

    deq_pkg::t_dq_cmd w_cmd;

    // Handshake sequencing: idle / result-held
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // Ring buffer, pointers and result registers
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule

`default_nettype wire
